### rtl/core/firc_pkg.sv
package firc_pkg;

  localparam int TAP_COUNT_W     = 6;
  localparam int COEF_INDEX_W    = 5;
  localparam int TAP_COUNT_RESET = 32;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

endpackage

### rtl/core/firc_if.sv
interface firc_in_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
);
  logic                                valid;
  logic                                ready;
  firc_pkg::op_t                       operation;
  logic signed [SAMPLE_WIDTH-1:0]      sample;
  logic [firc_pkg::COEF_INDEX_W-1:0]   coef_index;
  logic signed [COEF_WIDTH-1:0]        coef_value;
  logic                                end_of_batch;

  modport source (
    output valid, operation, sample, coef_index, coef_value, end_of_batch,
    input  ready
  );
  modport sink (
    input  valid, operation, sample, coef_index, coef_value, end_of_batch,
    output ready
  );
endinterface

interface firc_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           saturated;
  logic                           batch_end;

  modport source (
    output valid, filtered, saturated, batch_end,
    input  ready
  );
  modport sink (
    input  valid, filtered, saturated, batch_end,
    output ready
  );
endinterface

### rtl/core/firc_ram.sv
module firc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/fir_filter_circular_top.sv
// channel  | dir | payload
// ---------+-----+--------------------------------------------------------
// items    | in  | operation, sample, coef_index, coef_value, end_of_batch
// results  | out | filtered, saturated, batch_end
// cfg      | in  | cfg_we, cfg_data (tap_count)
//
// A coefficient load is written as it is accepted; a sample walks the L taps in use,
// with one multiply-accumulate per tap fed from the coefficient and sample RAMs.
// After reset a clearing pass zeroes every address of both RAMs; no item is taken then.
// The result register holds a finished item while the next item is accepted; a
// sample stalls at its last cycle until the previous result is taken.
module fir_filter_circular_top #(
  parameter int TAPS         = 32,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  firc_in_if.sink                            items,
  firc_out_if.source                         results,
  input  logic                               cfg_we,
  input  logic [firc_pkg::TAP_COUNT_W-1:0]   cfg_data
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int LW    = firc_pkg::TAP_COUNT_W;
  localparam int IW    = (AW > LW) ? AW : LW;
  localparam int FRAC  = COEF_WIDTH - 1;
  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W = (PW + LW > 64) ? 64 : PW + LW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                     state;
  logic [AW-1:0]              clr_cnt;
  logic [LW-1:0]              tap_count;
  logic [LW-1:0]              len;
  logic [AW-1:0]              write_position;
  logic [AW-1:0]              pos_eff;
  logic [AW-1:0]              pos_inc;
  logic [IW-1:0]              tap_cnt;
  logic [AW-1:0]              idx;
  logic                       rd_v;
  logic                       mul_v;
  logic signed [PW-1:0]       prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       batch_end_q;

  logic                       accept;
  logic                       load_ok;
  logic                       coef_we;
  logic [AW-1:0]              coef_waddr;
  logic [COEF_WIDTH-1:0]      coef_wdata;
  logic                       samp_we;
  logic [AW-1:0]              samp_waddr;
  logic [SAMPLE_WIDTH-1:0]    samp_wdata;
  logic [COEF_WIDTH-1:0]      coef_rdata;
  logic [SAMPLE_WIDTH-1:0]    samp_rdata;

  logic [ACC_W-FRAC-SAMPLE_WIDTH:0] top_bits;
  logic                             sat;
  logic signed [SAMPLE_WIDTH-1:0]   clipped;
  logic                             out_free;
  logic                             res_load;

  always_comb begin
    if (tap_count == '0) begin
      len = LW'(1);
    end else if (32'(tap_count) > TAPS) begin
      len = LW'(TAPS);
    end else begin
      len = tap_count;
    end
  end

  assign pos_eff = (IW'(write_position) >= IW'(len)) ? '0 : write_position;
  assign pos_inc = (IW'(pos_eff) + IW'(1) >= IW'(len)) ? '0 : AW'(pos_eff + AW'(1));

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign load_ok     = (32'(items.coef_index) < TAPS);

  assign coef_we    = (state == S_CLEAR) ||
                      (accept && items.operation == firc_pkg::OP_LOAD && load_ok);
  assign coef_waddr = (state == S_CLEAR) ? clr_cnt : AW'(items.coef_index);
  assign coef_wdata = (state == S_CLEAR) ? '0 : items.coef_value;

  assign samp_we    = (state == S_CLEAR) ||
                      (accept && items.operation == firc_pkg::OP_FILTER);
  assign samp_waddr = (state == S_CLEAR) ? clr_cnt : pos_eff;
  assign samp_wdata = (state == S_CLEAR) ? '0 : items.sample;

  firc_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (tap_cnt[AW-1:0]),
    .rdata (coef_rdata)
  );

  firc_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (TAPS)
  ) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (samp_wdata),
    .raddr (idx),
    .rdata (samp_rdata)
  );

  assign top_bits = acc[ACC_W-1:FRAC+SAMPLE_WIDTH-1];
  assign sat      = !((top_bits == '0) || (top_bits == '1));
  assign clipped  = sat ? (acc[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
                        : acc[FRAC+SAMPLE_WIDTH-1:FRAC];
  assign out_free = !results.valid || results.ready;
  assign res_load = (state == S_DRAIN) && !rd_v && !mul_v && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= LW'(firc_pkg::TAP_COUNT_RESET);
    end else if (cfg_we) begin
      tap_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(coef_rdata) * $signed(samp_rdata);
    if (accept && items.operation == firc_pkg::OP_FILTER) begin
      acc         <= ACC_W'(1) <<< (FRAC - 1);
      batch_end_q <= items.end_of_batch;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      write_position <= '0;
      tap_cnt        <= '0;
      idx            <= '0;
      rd_v           <= 1'b0;
      mul_v          <= 1'b0;
      results.valid  <= 1'b0;
    end else begin
      mul_v <= rd_v;
      if (res_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(TAPS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          rd_v <= 1'b0;
          if (accept && items.operation == firc_pkg::OP_FILTER) begin
            write_position <= pos_inc;
            tap_cnt        <= '0;
            idx            <= pos_eff;
            state          <= S_RUN;
          end
        end
        S_RUN: begin
          rd_v    <= 1'b1;
          tap_cnt <= tap_cnt + IW'(1);
          idx     <= (idx == '0) ? AW'(len - LW'(1)) : idx - AW'(1);
          if (tap_cnt == IW'(len - LW'(1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rd_v <= 1'b0;
          if (res_load) begin
            results.filtered  <= clipped;
            results.saturated <= sat;
            results.batch_end <= batch_end_q;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("reset did not start the clearing pass");

  a_sample_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && items.operation == firc_pkg::OP_FILTER) |=> state == S_RUN)
    else $error("sample item did not start the tap walk");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && items.operation == firc_pkg::OP_LOAD) |=> state == S_IDLE)
    else $error("coefficient load left idle");

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> IW'(tap_cnt) < IW'(len))
    else $error("tap counter ran past the tap count");

  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == S_DRAIN && !$past(mul_v))
    else $error("result raised before the sum was complete");
`endif

endmodule
